### src/vcv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcv_pkg
// Shared types, sizes and tap selection for the valid 2D convolution core.
// ----------------------------------------------------------------------------
package vcv_pkg;

  // Image and filter limits.
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int TAP_DIM     = 4;
  localparam int LINE_ROWS   = TAP_DIM - 1;
  localparam int CHANNELS    = 3;

  // Field widths.
  localparam int COORD_W     = 10;
  localparam int ADDR_W      = $clog2(MAX_WIDTH);
  localparam int SIZE_W      = 11;
  localparam int DIM_W       = 3;
  localparam int IDX_W       = $clog2(TAP_DIM);
  localparam int SAMPLE_W    = 16;
  localparam int PIXEL_W     = SAMPLE_W * CHANNELS;
  localparam int TAP_W       = 16;
  localparam int NUM_TAPS    = 16;
  localparam int TAP_IDX_W   = $clog2(NUM_TAPS);
  localparam int TAPS_W      = TAP_W * NUM_TAPS;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int PROD_W      = 2 * SAMPLE_W;
  localparam int COL_SUM_W   = PROD_W + $clog2(TAP_DIM);
  localparam int RESULT_W    = 40;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [TAP_W-1:0]    tap_t;
  typedef logic [PIXEL_W-1:0]         pixel_t;
  typedef pixel_t [TAP_DIM-1:0]       column_t;
  typedef pixel_t [LINE_ROWS-1:0]     line_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_FILTER_WIDTH  = 3'd2,
    REG_FILTER_HEIGHT = 3'd3,
    REG_TAPS_0        = 3'd4,
    REG_TAPS_1        = 3'd5,
    REG_TAPS_2        = 3'd6,
    REG_TAPS_3        = 3'd7
  } reg_index_t;

  // Position and control that travel with a word down the pipeline.
  typedef struct packed {
    logic               emit;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } pos_t;

  // One result word.
  typedef struct packed {
    logic [RESULT_W-1:0] sum_c0;
    logic [RESULT_W-1:0] sum_c1;
    logic [RESULT_W-1:0] sum_c2;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic                last;
  } result_word_t;

  // A window position takes part when it lies inside the bottom right
  // filter_height by filter_width corner of the window.
  function automatic logic tap_used(input logic [DIM_W-1:0] fw,
                                    input logic [DIM_W-1:0] fh,
                                    input logic [IDX_W-1:0] wy,
                                    input logic [IDX_W-1:0] wx);
    logic row_in;
    logic col_in;
    row_in = ((DIM_W+1)'(wy) + (DIM_W+1)'(fh)) >= (DIM_W+1)'(TAP_DIM);
    col_in = ((DIM_W+1)'(wx) + (DIM_W+1)'(fw)) >= (DIM_W+1)'(TAP_DIM);
    return row_in && col_in;
  endfunction

  // Tap for a window position; taps are numbered row-major over the
  // filter in use, and a number past the last tap reads as zero.
  function automatic tap_t tap_select(input logic [TAPS_W-1:0] taps,
                                      input logic [DIM_W-1:0]  fw,
                                      input logic [DIM_W-1:0]  fh,
                                      input logic [IDX_W-1:0]  wy,
                                      input logic [IDX_W-1:0]  wx);
    logic [DIM_W-1:0]       ry;
    logic [DIM_W-1:0]       cx;
    logic [TAP_IDX_W+1:0]   n;
    ry = DIM_W'(wy) + fh - DIM_W'(TAP_DIM);
    cx = DIM_W'(wx) + fw - DIM_W'(TAP_DIM);
    n  = (TAP_IDX_W+2)'(ry[IDX_W-1:0]) * (TAP_IDX_W+2)'(fw)
       + (TAP_IDX_W+2)'(cx[IDX_W-1:0]);
    if (n < (TAP_IDX_W+2)'(NUM_TAPS)) begin
      return taps[TAP_W * n[TAP_IDX_W-1:0] +: TAP_W];
    end
    return '0;
  endfunction

endpackage

### src/vcv_line_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcv_line_buffer
// Column history memory: the pixels of the previous rows at each column.
// ----------------------------------------------------------------------------
module vcv_line_buffer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [vcv_pkg::ADDR_W-1:0] rd_addr,
  input  logic                       wr_en,
  input  logic [vcv_pkg::ADDR_W-1:0] wr_addr,
  input  vcv_pkg::line_t             wr_data,
  output vcv_pkg::line_t             rd_data
);

  vcv_pkg::line_t mem [vcv_pkg::MAX_WIDTH];
  vcv_pkg::line_t mem_q;
  vcv_pkg::line_t fwd_data;
  logic           fwd_hit;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  // A read that meets a write to the same column takes the new data.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit ? fwd_data : mem_q;

endmodule

### src/vcv_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcv_cell
// One window column: holds its pixels, passes them to the left neighbor,
// and forms the tap-weighted sum of the column for each channel.
// ----------------------------------------------------------------------------
module vcv_cell (
  input  logic                  clk,
  input  logic                  advance,
  input  logic                  shift,
  input  vcv_pkg::column_t      column_in,
  input  vcv_pkg::tap_t         taps [vcv_pkg::TAP_DIM],
  input  logic [vcv_pkg::TAP_DIM-1:0] used,
  output vcv_pkg::column_t      column_out,
  output logic signed [vcv_pkg::COL_SUM_W-1:0] col_sum [vcv_pkg::CHANNELS]
);

  vcv_pkg::column_t column;
  logic signed [vcv_pkg::PROD_W-1:0] prod_c [vcv_pkg::TAP_DIM][vcv_pkg::CHANNELS];
  logic signed [vcv_pkg::PROD_W-1:0] prod   [vcv_pkg::TAP_DIM][vcv_pkg::CHANNELS];

  // Window column, loaded from the right neighbor on each shift.
  always_ff @(posedge clk) begin
    if (shift) begin
      column <= column_in;
    end
  end

  assign column_out = column;

  // One multiplier per row and channel.
  always_comb begin
    for (int y = 0; y < vcv_pkg::TAP_DIM; y++) begin
      for (int ch = 0; ch < vcv_pkg::CHANNELS; ch++) begin
        prod_c[y][ch] = $signed(column[y][vcv_pkg::SAMPLE_W*ch +: vcv_pkg::SAMPLE_W])
                      * taps[y];
      end
    end
  end

  // Products of unused positions are forced to zero.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int y = 0; y < vcv_pkg::TAP_DIM; y++) begin
        for (int ch = 0; ch < vcv_pkg::CHANNELS; ch++) begin
          prod[y][ch] <= used[y] ? prod_c[y][ch] : '0;
        end
      end
    end
  end

  // Column sum per channel.
  always_ff @(posedge clk) begin
    logic signed [vcv_pkg::COL_SUM_W-1:0] acc;
    if (advance) begin
      for (int ch = 0; ch < vcv_pkg::CHANNELS; ch++) begin
        acc = '0;
        for (int y = 0; y < vcv_pkg::TAP_DIM; y++) begin
          acc = acc + vcv_pkg::COL_SUM_W'(prod[y][ch]);
        end
        col_sum[ch] <= acc;
      end
    end
  end

endmodule

### src/valid_2d_convolution_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valid_2d_convolution_core
// Valid-mode 2D correlation of a raster-order three-channel pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on the sample channel (sample_valid / sample_ready), one word
// per pixel in raster order. Each pixel whose filter window lies wholly
// inside the image yields one word on the result channel (result_valid /
// result_ready) with the three window sums, the output row and column and
// a mark on the final word of the image; other pixels yield nothing.
// Configuration is written through cfg_write / cfg_index / cfg_data while
// the core is idle.
// Throughput is one pixel per cycle while the skid register is empty. A
// result word passes in order through the line memory read, the shift into
// the window column, the registered products, the column sums and the sum
// across the cells into the output register.
// Reset returns the configuration registers to their defaults, zeroes the
// position counters and empties the pipeline; the line memory is not cleared.
// When the receiver stalls, one further word is held in a skid register;
// sample_ready drops while that register is full and the pipeline freezes.
// ----------------------------------------------------------------------------
module valid_2d_convolution_core (
  input  logic                                   clk,
  input  logic                                   rst,
  // Configuration write port.
  input  logic                                   cfg_write,
  input  logic [vcv_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [vcv_pkg::CFG_W-1:0]              cfg_data,
  // Pixel channel.
  input  logic                                   sample_valid,
  output logic                                   sample_ready,
  input  logic signed [vcv_pkg::SAMPLE_W-1:0]    sample_c0,
  input  logic signed [vcv_pkg::SAMPLE_W-1:0]    sample_c1,
  input  logic signed [vcv_pkg::SAMPLE_W-1:0]    sample_c2,
  // Result channel.
  output logic                                   result_valid,
  input  logic                                   result_ready,
  output logic signed [vcv_pkg::RESULT_W-1:0]    result_c0,
  output logic signed [vcv_pkg::RESULT_W-1:0]    result_c1,
  output logic signed [vcv_pkg::RESULT_W-1:0]    result_c2,
  output logic [vcv_pkg::COORD_W-1:0]            out_row,
  output logic [vcv_pkg::COORD_W-1:0]            out_col,
  output logic                                   last_result
);

  localparam int TD = vcv_pkg::TAP_DIM;
  localparam int CH = vcv_pkg::CHANNELS;

  // Configuration registers.
  logic [vcv_pkg::SIZE_W-1:0] image_width;
  logic [vcv_pkg::SIZE_W-1:0] image_height;
  logic [vcv_pkg::DIM_W-1:0]  filter_width;
  logic [vcv_pkg::DIM_W-1:0]  filter_height;
  logic [vcv_pkg::TAPS_W-1:0] taps;

  // Effective sizes after clamping.
  logic [vcv_pkg::SIZE_W-1:0] eff_w;
  logic [vcv_pkg::SIZE_W-1:0] eff_h;
  logic [vcv_pkg::DIM_W-1:0]  eff_fw;
  logic [vcv_pkg::DIM_W-1:0]  eff_fh;

  // Position counters.
  logic [vcv_pkg::COORD_W-1:0] col_count;
  logic [vcv_pkg::COORD_W-1:0] row_count;
  logic [vcv_pkg::COORD_W-1:0] col_count_next;
  logic [vcv_pkg::COORD_W-1:0] row_count_next;
  logic [vcv_pkg::SIZE_W-1:0]  col_plus;
  logic [vcv_pkg::SIZE_W-1:0]  row_plus;

  // Pipeline control.
  logic          advance;
  logic          accept;
  vcv_pkg::pos_t in_pos;
  logic          s1_valid;
  logic          s2_valid;
  logic          s3_valid;
  logic          s4_valid;
  vcv_pkg::pos_t s1_pos;
  vcv_pkg::pos_t s2_pos;
  vcv_pkg::pos_t s3_pos;
  vcv_pkg::pos_t s4_pos;
  logic [vcv_pkg::ADDR_W-1:0] s1_addr;
  vcv_pkg::pixel_t s1_pix;

  // Line memory and window chain.
  vcv_pkg::line_t   line_rd;
  vcv_pkg::line_t   line_wr;
  vcv_pkg::column_t new_column;
  vcv_pkg::column_t cell_out [TD];
  vcv_pkg::tap_t    cell_taps [TD][TD];
  logic [TD-1:0]    cell_used [TD];
  logic signed [vcv_pkg::COL_SUM_W-1:0] cell_sum [TD][CH];
  logic signed [vcv_pkg::RESULT_W-1:0]  total [CH];

  // Output register and skid register.
  logic                  push;
  vcv_pkg::result_word_t push_word;
  vcv_pkg::result_word_t out_word;
  vcv_pkg::result_word_t skid_word;
  logic                  skid_valid;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= vcv_pkg::SIZE_W'(1);
      image_height  <= vcv_pkg::SIZE_W'(1);
      filter_width  <= vcv_pkg::DIM_W'(1);
      filter_height <= vcv_pkg::DIM_W'(1);
      taps          <= vcv_pkg::TAPS_W'(256);
    end else if (cfg_write) begin
      case (vcv_pkg::reg_index_t'(cfg_index))
        vcv_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data[vcv_pkg::SIZE_W-1:0];
        vcv_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data[vcv_pkg::SIZE_W-1:0];
        vcv_pkg::REG_FILTER_WIDTH:  filter_width  <= cfg_data[vcv_pkg::DIM_W-1:0];
        vcv_pkg::REG_FILTER_HEIGHT: filter_height <= cfg_data[vcv_pkg::DIM_W-1:0];
        vcv_pkg::REG_TAPS_0:        taps[0*vcv_pkg::CFG_W +: vcv_pkg::CFG_W] <= cfg_data;
        vcv_pkg::REG_TAPS_1:        taps[1*vcv_pkg::CFG_W +: vcv_pkg::CFG_W] <= cfg_data;
        vcv_pkg::REG_TAPS_2:        taps[2*vcv_pkg::CFG_W +: vcv_pkg::CFG_W] <= cfg_data;
        vcv_pkg::REG_TAPS_3:        taps[3*vcv_pkg::CFG_W +: vcv_pkg::CFG_W] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero counts as one, and values above the limits count as the limit.
  always_comb begin
    eff_w  = image_width;
    eff_h  = image_height;
    eff_fw = filter_width;
    eff_fh = filter_height;
    if (image_width == '0) begin
      eff_w = vcv_pkg::SIZE_W'(1);
    end else if (image_width > vcv_pkg::SIZE_W'(vcv_pkg::MAX_WIDTH)) begin
      eff_w = vcv_pkg::SIZE_W'(vcv_pkg::MAX_WIDTH);
    end
    if (image_height == '0) begin
      eff_h = vcv_pkg::SIZE_W'(1);
    end else if (image_height > vcv_pkg::SIZE_W'(vcv_pkg::MAX_HEIGHT)) begin
      eff_h = vcv_pkg::SIZE_W'(vcv_pkg::MAX_HEIGHT);
    end
    if (filter_width == '0) begin
      eff_fw = vcv_pkg::DIM_W'(1);
    end else if (filter_width > vcv_pkg::DIM_W'(TD)) begin
      eff_fw = vcv_pkg::DIM_W'(TD);
    end
    if (filter_height == '0) begin
      eff_fh = vcv_pkg::DIM_W'(1);
    end else if (filter_height > vcv_pkg::DIM_W'(TD)) begin
      eff_fh = vcv_pkg::DIM_W'(TD);
    end
  end

  // The whole pipeline moves unless the skid register holds a word.
  assign advance      = !skid_valid;
  assign sample_ready = advance;
  assign accept       = sample_valid && advance;

  // Output position of the incoming pixel and the counter update.
  always_comb begin
    col_plus = vcv_pkg::SIZE_W'(col_count) + vcv_pkg::SIZE_W'(1);
    row_plus = vcv_pkg::SIZE_W'(row_count) + vcv_pkg::SIZE_W'(1);
    in_pos.emit = (col_plus >= vcv_pkg::SIZE_W'(eff_fw))
               && (row_plus >= vcv_pkg::SIZE_W'(eff_fh))
               && (vcv_pkg::SIZE_W'(eff_fw) <= eff_w)
               && (vcv_pkg::SIZE_W'(eff_fh) <= eff_h);
    in_pos.row  = vcv_pkg::COORD_W'(row_plus - vcv_pkg::SIZE_W'(eff_fh));
    in_pos.col  = vcv_pkg::COORD_W'(col_plus - vcv_pkg::SIZE_W'(eff_fw));
    in_pos.last = (col_plus >= eff_w) && (row_plus >= eff_h);
    col_count_next = col_plus[vcv_pkg::COORD_W-1:0];
    row_count_next = row_count;
    if (col_plus >= eff_w) begin
      col_count_next = '0;
      row_count_next = (row_plus >= eff_h) ? '0 : row_plus[vcv_pkg::COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= sample_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_pos  <= in_pos;
      s1_addr <= col_count[vcv_pkg::ADDR_W-1:0];
      s1_pix  <= {sample_c2, sample_c1, sample_c0};
      s2_pos  <= s1_pos;
      s3_pos  <= s2_pos;
      s4_pos  <= s3_pos;
    end
  end

  // Column history: newest previous row in slot zero.
  vcv_line_buffer u_line_buffer (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (col_count[vcv_pkg::ADDR_W-1:0]),
    .wr_en   (advance && s1_valid),
    .wr_addr (s1_addr),
    .wr_data (line_wr),
    .rd_data (line_rd)
  );

  // New window column and the shifted history written back.
  always_comb begin
    new_column[TD-1] = s1_pix;
    line_wr[0]       = s1_pix;
    for (int y = 0; y < vcv_pkg::LINE_ROWS; y++) begin
      new_column[y] = line_rd[vcv_pkg::LINE_ROWS-1-y];
    end
    for (int y = 1; y < vcv_pkg::LINE_ROWS; y++) begin
      line_wr[y] = line_rd[y-1];
    end
  end

  // Taps and use flags for each window position.
  always_comb begin
    for (int x = 0; x < TD; x++) begin
      for (int y = 0; y < TD; y++) begin
        cell_taps[x][y] = vcv_pkg::tap_select(taps, eff_fw, eff_fh,
                                              vcv_pkg::IDX_W'(y), vcv_pkg::IDX_W'(x));
        cell_used[x][y] = vcv_pkg::tap_used(eff_fw, eff_fh,
                                            vcv_pkg::IDX_W'(y), vcv_pkg::IDX_W'(x));
      end
    end
  end

  // Chain of window column cells; the rightmost takes the new column.
  for (genvar x = 0; x < TD; x++) begin : g_cell
    vcv_pkg::column_t chain_in;
    if (x == TD - 1) begin : g_head
      assign chain_in = new_column;
    end else begin : g_link
      assign chain_in = cell_out[x+1];
    end
    vcv_cell u_cell (
      .clk        (clk),
      .advance    (advance),
      .shift      (advance && s1_valid),
      .column_in  (chain_in),
      .taps       (cell_taps[x]),
      .used       (cell_used[x]),
      .column_out (cell_out[x]),
      .col_sum    (cell_sum[x])
    );
  end

  // Sum across the cells.
  always_comb begin
    logic signed [vcv_pkg::RESULT_W-1:0] acc;
    for (int ch = 0; ch < CH; ch++) begin
      acc = '0;
      for (int x = 0; x < TD; x++) begin
        acc = acc + vcv_pkg::RESULT_W'(cell_sum[x][ch]);
      end
      total[ch] = acc;
    end
  end

  assign push             = advance && s4_valid && s4_pos.emit;
  assign push_word.sum_c0 = total[0];
  assign push_word.sum_c1 = total[1];
  assign push_word.sum_c2 = total[2];
  assign push_word.row    = s4_pos.row;
  assign push_word.col    = s4_pos.col;
  assign push_word.last   = s4_pos.last;

  // Output register with one skid word behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || result_ready) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || result_ready) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (push) begin
        out_word <= push_word;
      end
    end else if (push) begin
      skid_word <= push_word;
    end
  end

  assign result_c0   = out_word.sum_c0;
  assign result_c1   = out_word.sum_c1;
  assign result_c2   = out_word.sum_c2;
  assign out_row     = out_word.row;
  assign out_col     = out_word.col;
  assign last_result = out_word.last;

endmodule

### bench/valid_2d_convolution_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valid_2d_convolution_core_tb
// Self-checking bench for the valid 2D convolution core.
// ----------------------------------------------------------------------------
// Whole images are streamed through the pixel channel while both the sender
// and the receiver pause at random. A behavioral model of the core, kept in
// this file, turns every accepted pixel into the result word it should
// cause, and each result word is compared field by field with the oldest
// one still outstanding. Geometry and taps change only between images, once
// the core has gone quiet. A short directed part covers the reset defaults,
// clamped sizes, a filter larger than the image and the full 4x4 filter;
// random images follow, and a long single row and a tall single column
// close the run.
// ----------------------------------------------------------------------------
module valid_2d_convolution_core_tb;
  import vcv_pkg::*;

  localparam int unsigned RANDOM_PIXELS  = 400;
  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 30;

  logic                        clk;
  logic                        rst;
  logic                        cfg_write;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]            cfg_data;
  logic                        sample_valid;
  logic                        sample_ready;
  sample_t                     sample_c0;
  sample_t                     sample_c1;
  sample_t                     sample_c2;
  logic                        result_valid;
  logic                        result_ready;
  logic signed [RESULT_W-1:0]  result_c0;
  logic signed [RESULT_W-1:0]  result_c1;
  logic signed [RESULT_W-1:0]  result_c2;
  logic [COORD_W-1:0]          out_row;
  logic [COORD_W-1:0]          out_col;
  logic                        last_result;

  valid_2d_convolution_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_c0    (sample_c0),
    .sample_c1    (sample_c1),
    .sample_c2    (sample_c2),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_c0    (result_c0),
    .result_c1    (result_c1),
    .result_c2    (result_c2),
    .out_row      (out_row),
    .out_col      (out_col),
    .last_result  (last_result)
  );

  // Shadow of the configuration registers.
  logic [SIZE_W-1:0]   img_w_reg;
  logic [SIZE_W-1:0]   img_h_reg;
  logic [DIM_W-1:0]    flt_w_reg;
  logic [DIM_W-1:0]    flt_h_reg;
  logic [CFG_W-1:0]    tap_bank [4];

  // Model state: recent rows per column, the 4x4 window and the position.
  pixel_t              line_mem [LINE_ROWS][MAX_WIDTH];
  pixel_t              window_px [TAP_DIM][TAP_DIM];
  int unsigned         col_pos;
  int unsigned         row_pos;

  // Result words still owed by the core, oldest first.
  result_word_t        expected_sums [$];

  int unsigned         pixels_sent;
  int unsigned         words_checked;
  int unsigned         reg_writes;
  int unsigned         error_count;
  int unsigned         calm_items;
  int unsigned         quiet_cycles;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(int unsigned value, int unsigned hi);
    if (value == 0) return 1;
    return (value > hi) ? hi : value;
  endfunction

  function automatic int unsigned image_pixels();
    return clamp_dim(img_w_reg, MAX_WIDTH) * clamp_dim(img_h_reg, MAX_HEIGHT);
  endfunction

  // Tap n of the row-major filter; numbers past the bank read as zero.
  function automatic tap_t tap_value(int unsigned n);
    if (n >= NUM_TAPS) return '0;
    return tap_bank[n / 4][TAP_W * (n % 4) +: TAP_W];
  endfunction

  function automatic void clear_model();
    img_w_reg = SIZE_W'(1);
    img_h_reg = SIZE_W'(1);
    flt_w_reg = DIM_W'(1);
    flt_h_reg = DIM_W'(1);
    tap_bank[0] = CFG_W'(256);
    tap_bank[1] = '0;
    tap_bank[2] = '0;
    tap_bank[3] = '0;
    foreach (line_mem[y, x]) line_mem[y][x] = '0;
    foreach (window_px[y, x]) window_px[y][x] = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Advance the model by one pixel and queue the word it causes, if any.
  function automatic void predict_pixel(sample_t s0, sample_t s1, sample_t s2);
    int unsigned         w;
    int unsigned         h;
    int unsigned         fw;
    int unsigned         fh;
    int unsigned         c;
    int unsigned         r;
    pixel_t              pix;
    longint              acc;
    sample_t             smp;
    tap_t                tp;
    logic [RESULT_W-1:0] sums [CHANNELS];
    result_word_t        word;
    w   = clamp_dim(img_w_reg, MAX_WIDTH);
    h   = clamp_dim(img_h_reg, MAX_HEIGHT);
    fw  = clamp_dim(flt_w_reg, TAP_DIM);
    fh  = clamp_dim(flt_h_reg, TAP_DIM);
    c   = col_pos;
    r   = row_pos;
    pix = {s2, s1, s0};

    // Shift the window left; the new column is the column history plus
    // this pixel at the bottom.
    for (int y = 0; y < TAP_DIM; y++) begin
      for (int x = 0; x < TAP_DIM - 1; x++) window_px[y][x] = window_px[y][x + 1];
    end
    for (int y = 0; y < LINE_ROWS; y++) window_px[y][TAP_DIM - 1] = line_mem[LINE_ROWS - 1 - y][c];
    window_px[TAP_DIM - 1][TAP_DIM - 1] = pix;
    for (int y = LINE_ROWS - 1; y > 0; y--) line_mem[y][c] = line_mem[y - 1][c];
    line_mem[0][c] = pix;

    // The window lies wholly inside the image.
    if (c + 1 >= fw && r + 1 >= fh && fw <= w && fh <= h) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        acc = 0;
        for (int unsigned y = 0; y < fh; y++) begin
          for (int unsigned x = 0; x < fw; x++) begin
            smp = window_px[TAP_DIM - fh + y][TAP_DIM - fw + x][SAMPLE_W * ch +: SAMPLE_W];
            tp  = tap_value(y * fw + x);
            acc += longint'(smp) * longint'(tp);
          end
        end
        sums[ch] = RESULT_W'(acc);
      end
      word.sum_c0 = sums[0];
      word.sum_c1 = sums[1];
      word.sum_c2 = sums[2];
      word.row    = COORD_W'(r + 1 - fh);
      word.col    = COORD_W'(c + 1 - fw);
      word.last   = (c + 1 >= w) && (r + 1 >= h);
      expected_sums.push_back(word);
    end

    // Step to the next pixel, wrapping at the end of a row and of the image.
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  // Samples lean toward the extremes so that sums reach their widest.
  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3:       return 16'shFFFF;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_taps();
    logic [CFG_W-1:0] bank;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 7))
        0:       bank[TAP_W * i +: TAP_W] = 16'h7FFF;
        1:       bank[TAP_W * i +: TAP_W] = 16'h8000;
        2:       bank[TAP_W * i +: TAP_W] = 16'h0000;
        default: bank[TAP_W * i +: TAP_W] = TAP_W'($urandom);
      endcase
    end
    return bank;
  endfunction

  // Size value with random junk above the register width half the time.
  function automatic logic [CFG_W-1:0] with_noise(int unsigned value, int unsigned bits);
    logic [CFG_W-1:0] low_mask;
    logic [CFG_W-1:0] word;
    low_mask = (CFG_W'(1) << bits) - CFG_W'(1);
    word     = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 0) word = '0;
    return (word & ~low_mask) | (CFG_W'(value) & low_mask);
  endfunction

  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm_items > 0) begin
      calm_items--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      calm_items = $urandom_range(16, 64);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < MAX_REPORTS) begin
      $display("mismatch in %s at word %0d: got %h, expected %h", what, words_checked,
               got, want);
    end
    error_count++;
  endtask

  // Register write through the configuration port; the shadow follows.
  task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:   img_w_reg = value[SIZE_W-1:0];
      REG_IMAGE_HEIGHT:  img_h_reg = value[SIZE_W-1:0];
      REG_FILTER_WIDTH:  flt_w_reg = value[DIM_W-1:0];
      REG_FILTER_HEIGHT: flt_h_reg = value[DIM_W-1:0];
      REG_TAPS_0:        tap_bank[0] = value;
      REG_TAPS_1:        tap_bank[1] = value;
      REG_TAPS_2:        tap_bank[2] = value;
      REG_TAPS_3:        tap_bank[3] = value;
      default:           ;
    endcase
    reg_writes++;
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h,
                              input int unsigned fw, input int unsigned fh);
    write_reg(REG_IMAGE_WIDTH, with_noise(w, SIZE_W));
    write_reg(REG_IMAGE_HEIGHT, with_noise(h, SIZE_W));
    write_reg(REG_FILTER_WIDTH, with_noise(fw, DIM_W));
    write_reg(REG_FILTER_HEIGHT, with_noise(fh, DIM_W));
  endtask

  // Offer one pixel word and hold it until the core takes it.
  task automatic send_pixel(input sample_t s0, input sample_t s1, input sample_t s2);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample_c0    <= s0;
    sample_c1    <= s1;
    sample_c2    <= s2;
    do @(posedge clk); while (!sample_ready);
    predict_pixel(s0, s1, s2);
    pixels_sent++;
  endtask

  task automatic send_image(input int unsigned count);
    repeat (count) send_pixel(rand_sample(), rand_sample(), rand_sample());
  endtask

  // Let every owed word arrive, then give the pipeline time to empty.
  task automatic drain_results();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reset defaults: a 1x1 image and a 1x1 filter with a tap of 256, so each
  // pixel is its own image and comes back scaled by 256.
  task automatic test_reset_defaults();
    send_pixel(16'sh7FFF, 16'sh8000, 16'sh0001);
    send_pixel(16'sh8000, 16'sh7FFF, 16'shFFFF);
    send_pixel(16'sh0000, 16'shFFFF, 16'sh5555);
    drain_results();
  endtask

  // Zero sizes count as one; only tap 0 of the bank is in use.
  task automatic test_clamped_sizes();
    set_geometry(0, 0, 0, 0);
    write_reg(REG_TAPS_0, {48'hA5A5_0F0F_7FFF, 16'h8000});
    send_pixel(16'sh8000, 16'sh7FFF, 16'sh0000);
    send_pixel(16'sh8000, 16'sh8000, 16'sh8000);
    drain_results();
  endtask

  // A filter wider than the image gives no words, yet the image completes.
  task automatic test_filter_exceeds_image();
    set_geometry(2, 2, 3, 1);
    send_image(image_pixels());
    drain_results();
  endtask

  // Oversized filter dimensions clamp to the full 4x4 filter.
  task automatic test_full_filter();
    set_geometry(4, 4, 7, 7);
    write_reg(REG_TAPS_0, {16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF});
    write_reg(REG_TAPS_1, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
    write_reg(REG_TAPS_2, rand_taps());
    write_reg(REG_TAPS_3, {16'h8000, 16'h0100, 16'h7FFF, 16'h8000});
    send_image(image_pixels());
    drain_results();
  endtask

  // Random geometry and taps, a few whole images per setting.
  task automatic test_random_images();
    int unsigned start_count;
    int unsigned w;
    int unsigned h;
    int unsigned fw;
    int unsigned fh;
    start_count = pixels_sent;
    while (pixels_sent - start_count < RANDOM_PIXELS) begin
      w  = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
      h  = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
      fw = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
      fh = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
      set_geometry(w, h, fw, fh);
      for (int i = 0; i < 4; i++) begin
        if ($urandom_range(0, 2) != 0) begin
          write_reg(reg_index_t'(int'(REG_TAPS_0) + i), rand_taps());
        end
      end
      repeat ($urandom_range(1, 3)) send_image(image_pixels());
      drain_results();
    end
  endtask

  // One long row with a wide filter and one tall column with a tall filter.
  task automatic test_long_shapes();
    set_geometry(150, 1, 4, 1);
    write_reg(REG_TAPS_0, rand_taps());
    send_image(image_pixels());
    drain_results();
    set_geometry(1, 40, 1, 4);
    send_image(image_pixels());
    drain_results();
  endtask

  // Receiver: ready in segments of random length and level.
  initial begin
    int unsigned hold;
    int unsigned roll;
    result_ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
          result_ready <= 1'b1;
          hold = $urandom_range(1, 12);
        end else if (roll < 58) begin
          result_ready <= 1'b1;
          hold = $urandom_range(30, 90);
        end else if (roll < 92) begin
          result_ready <= 1'b0;
          hold = $urandom_range(1, 3);
        end else begin
          result_ready <= 1'b0;
          hold = $urandom_range(8, 30);
        end
      end
      hold--;
    end
  end

  // Compare each accepted result word with the oldest outstanding one.
  always @(posedge clk) begin
    result_word_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_sums.size() == 0) begin
        report_mismatch("unexpected word", {out_row, out_col}, '0);
      end else begin
        want = expected_sums.pop_front();
        if (result_c0 !== want.sum_c0) report_mismatch("result_c0", result_c0, want.sum_c0);
        if (result_c1 !== want.sum_c1) report_mismatch("result_c1", result_c1, want.sum_c1);
        if (result_c2 !== want.sum_c2) report_mismatch("result_c2", result_c2, want.sum_c2);
        if (out_row !== want.row) report_mismatch("out_row", out_row, want.row);
        if (out_col !== want.col) report_mismatch("out_col", out_col, want.col);
        if (last_result !== want.last) report_mismatch("last_result", last_result, want.last);
      end
      words_checked++;
    end
  end

  // Watchdog: too long without any word moving on either channel.
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = REG_IMAGE_WIDTH;
    cfg_data      = '0;
    sample_valid  = 1'b0;
    sample_c0     = '0;
    sample_c1     = '0;
    sample_c2     = '0;
    pixels_sent   = 0;
    words_checked = 0;
    reg_writes    = 0;
    error_count   = 0;
    calm_items    = 0;
    quiet_cycles  = 0;
    clear_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_clamped_sizes();
    test_filter_exceeds_image();
    test_full_filter();
    test_random_images();
    test_long_shapes();

    if (expected_sums.size() != 0) begin
      report_mismatch("missing words", expected_sums.size(), '0);
    end
    $display("Sent %0d pixels, checked %0d result words, made %0d register writes.",
             pixels_sent, words_checked, reg_writes);
    $display("Images ran from 1x1 up to 150 wide or 40 tall, filters from 1x1 to 4x4.");
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### valid_2d_convolution_core.f
src/vcv_pkg.sv
src/vcv_line_buffer.sv
src/vcv_cell.sv
src/valid_2d_convolution_core.sv
bench/valid_2d_convolution_core_tb.sv
